// File: design/pidc_pkg.sv
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types, constants and the microcode table of the PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned LIM_W  = 31;
  localparam int unsigned OPND_W = 33;
  localparam int unsigned PROD_W = 2 * OPND_W;
  localparam int unsigned SUM_W  = 52;
  localparam int unsigned PC_W   = 3;
  localparam int unsigned ADDR_W = 5;

  // Register indexes on the configuration port (byte address is 4 * index).
  localparam logic [2:0] REG_GAIN_P         = 3'd0;
  localparam logic [2:0] REG_GAIN_I         = 3'd1;
  localparam logic [2:0] REG_GAIN_D         = 3'd2;
  localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd3;
  localparam logic [2:0] REG_SETPOINT       = 3'd4;
  localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd5;
  localparam logic [2:0] REG_OUTPUT_LIMIT   = 3'd6;

  localparam logic [DATA_W-1:0] SAMPLE_PERIOD_RST  = 32'd4294967;
  localparam logic [LIM_W-1:0]  INTEGRAL_LIMIT_RST = 31'd22937600;
  localparam logic [LIM_W-1:0]  OUTPUT_LIMIT_RST   = 31'd65470464;

  // Program steps.
  localparam logic [PC_W-1:0] STEP_ERR     = 3'd0;
  localparam logic [PC_W-1:0] STEP_INCR    = 3'd1;
  localparam logic [PC_W-1:0] STEP_ACC     = 3'd2;
  localparam logic [PC_W-1:0] STEP_P_TERM  = 3'd3;
  localparam logic [PC_W-1:0] STEP_I_TERM  = 3'd4;
  localparam logic [PC_W-1:0] STEP_D_TERM  = 3'd5;
  localparam logic [PC_W-1:0] STEP_OUT     = 3'd6;
  localparam logic [PC_W-1:0] STEP_CLEAR   = 3'd7;

  typedef enum logic [1:0] {MA_ERR, MA_GAIN_P, MA_GAIN_I, MA_GAIN_D} mul_a_e;
  typedef enum logic [1:0] {MB_PERIOD, MB_ERR, MB_ACC, MB_DERR} mul_b_e;
  typedef enum logic [1:0] {SUM_HOLD, SUM_CLR, SUM_ADD} sum_op_e;

  typedef struct packed {
    logic            err_en;
    logic            br_clr;
    logic [PC_W-1:0] br_tgt;
    logic            mul_en;
    mul_a_e          mul_a;
    mul_b_e          mul_b;
    logic            acc_en;
    sum_op_e         sum_op;
    logic            last_en;
    logic            out_en;
    logic            clr_en;
    logic            end_prog;
  } ctrl_t;

  // One control word per step. The multiplier result is registered, so
  // a step that uses a product consumes the one made in the step before.
  function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w          = '0;
    w.mul_a    = MA_ERR;
    w.mul_b    = MB_PERIOD;
    w.sum_op   = SUM_HOLD;
    w.br_tgt   = STEP_CLEAR;
    case (pc)
      STEP_ERR: begin
        w.err_en = 1'b1;
        w.br_clr = 1'b1;
      end
      STEP_INCR: begin
        w.mul_en = 1'b1;
        w.mul_a  = MA_ERR;
        w.mul_b  = MB_PERIOD;
      end
      STEP_ACC: begin
        w.acc_en = 1'b1;
        w.sum_op = SUM_CLR;
        w.mul_en = 1'b1;
        w.mul_a  = MA_GAIN_P;
        w.mul_b  = MB_ERR;
      end
      STEP_P_TERM: begin
        w.sum_op = SUM_ADD;
        w.mul_en = 1'b1;
        w.mul_a  = MA_GAIN_I;
        w.mul_b  = MB_ACC;
      end
      STEP_I_TERM: begin
        w.sum_op = SUM_ADD;
        w.mul_en = 1'b1;
        w.mul_a  = MA_GAIN_D;
        w.mul_b  = MB_DERR;
      end
      STEP_D_TERM: begin
        w.sum_op  = SUM_ADD;
        w.last_en = 1'b1;
      end
      STEP_OUT: begin
        w.out_en   = 1'b1;
        w.end_prog = 1'b1;
      end
      STEP_CLEAR: begin
        w.clr_en   = 1'b1;
        w.end_prog = 1'b1;
      end
      default: begin
        w.end_prog = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/pidc_seq.sv
// ----------------------------------------------------------------------------
// pidc_seq
// Microcode sequencer: step counter, control table and conditional branch.
// ----------------------------------------------------------------------------
module pidc_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           clr_i,
  input  logic           hold_i,
  output pidc_pkg::ctrl_t ctrl_o,
  output logic           busy_o,
  output logic           fire_o
);
  import pidc_pkg::*;

  logic [PC_W-1:0] pc_q, pc_d;
  logic            busy_q, busy_d;

  assign ctrl_o = ucode_rom(pc_q);
  // The output step waits while the previous result is still held.
  assign fire_o = busy_q & ~(ctrl_o.out_en & hold_i);
  assign busy_o = busy_q;

  always_comb begin
    pc_d   = pc_q;
    busy_d = busy_q;
    if (!busy_q) begin
      if (start_i) begin
        pc_d   = STEP_ERR;
        busy_d = 1'b1;
      end
    end else if (fire_o) begin
      if (ctrl_o.end_prog) begin
        busy_d = 1'b0;
      end else if (ctrl_o.br_clr && clr_i) begin
        pc_d = ctrl_o.br_tgt;
      end else begin
        pc_d = pc_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= STEP_ERR;
      busy_q <= 1'b0;
    end else begin
      pc_q   <= pc_d;
      busy_q <= busy_d;
    end
  end

endmodule

// File: design/pid_controller_clamped_unit.sv
// ----------------------------------------------------------------------------
// pid_controller_clamped_unit
// Discrete PID controller with integral anti-windup and output clamping.
// ----------------------------------------------------------------------------
// Usage: software sets gains, sample period, setpoint and limits over the
// APB-style port while the block is idle. Each input transaction carries a
// function bit and a measured value. An update (func 0) produces one output
// transaction with the clamped drive value; a clear (func 1) zeroes the
// integral and the previous error and produces no output.
// Sequencing: a microcoded program runs one step per cycle on a single shared
// 33 x 33 multiplier, except while the output step waits on a held result.
// An update runs the error, increment, accumulate, P, I and D term and output
// steps; a clear runs the error and clear steps. The multiplier is used four
// times in a row. A new item is taken only after the program has ended.
// Reset: the configuration registers return to their default values, the
// integral and previous error are zeroed, and no output is pending.
// Stall: a finished result waits in the output register while the receiver
// stalls; the next item is still accepted and computed, and only its final
// step waits until the register is free.
// ----------------------------------------------------------------------------
module pid_controller_clamped_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic signed [31:0]              measured_i,
  // Output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [31:0]              drive_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pidc_pkg::ADDR_W-1:0]     paddr,
  input  logic [pidc_pkg::DATA_W-1:0]     pwdata,
  output logic [pidc_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import pidc_pkg::*;

  // Configuration registers
  logic signed [DATA_W-1:0] gain_p_q, gain_i_q, gain_d_q, setpoint_q;
  logic [DATA_W-1:0]        period_q;
  logic [LIM_W-1:0]         ilim_q, olim_q;

  // Datapath registers
  logic                     func_q;
  logic signed [DATA_W-1:0] meas_q;
  logic signed [DATA_W-1:0] err_q, acc_q, last_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [DATA_W-1:0] drive_q;
  logic                     out_valid_q;

  ctrl_t ctrl;
  logic  busy, fire, in_accept, cfg_wr;

  logic signed [OPND_W-1:0] diff, derr, opa, opb;
  logic signed [DATA_W-1:0] err_d, acc_d, drive_d;
  logic signed [OPND_W-1:0] acc_sum, ilim_ext, ilim_neg;
  logic signed [SUM_W-1:0]  term, olim_ext, sum_next;

  assign in_accept = in_valid_i & ~in_stall_o;
  assign in_stall_o = busy;

  pidc_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .clr_i   (func_q),
    .hold_i  (out_valid_q & out_stall_i),
    .ctrl_o  (ctrl),
    .busy_o  (busy),
    .fire_o  (fire)
  );

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      period_q   <= SAMPLE_PERIOD_RST;
      setpoint_q <= '0;
      ilim_q     <= INTEGRAL_LIMIT_RST;
      olim_q     <= OUTPUT_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_GAIN_P:         gain_p_q   <= pwdata;
        REG_GAIN_I:         gain_i_q   <= pwdata;
        REG_GAIN_D:         gain_d_q   <= pwdata;
        REG_SAMPLE_PERIOD:  period_q   <= pwdata;
        REG_SETPOINT:       setpoint_q <= pwdata;
        REG_INTEGRAL_LIMIT: ilim_q     <= pwdata[LIM_W-1:0];
        REG_OUTPUT_LIMIT:   olim_q     <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_GAIN_P:         prdata = gain_p_q;
      REG_GAIN_I:         prdata = gain_i_q;
      REG_GAIN_D:         prdata = gain_d_q;
      REG_SAMPLE_PERIOD:  prdata = period_q;
      REG_SETPOINT:       prdata = setpoint_q;
      REG_INTEGRAL_LIMIT: prdata = {1'b0, ilim_q};
      REG_OUTPUT_LIMIT:   prdata = {1'b0, olim_q};
      default:            prdata = '0;
    endcase
  end

  // Error with saturation. A difference of exactly the most negative value
  // maps to one above it, while anything below maps to the most negative.
  assign diff = {setpoint_q[DATA_W-1], setpoint_q} - {meas_q[DATA_W-1], meas_q};

  always_comb begin
    if (!diff[OPND_W-1] && diff[OPND_W-2]) begin
      err_d = 32'sh7FFF_FFFF;
    end else if (diff[OPND_W-1] && !diff[OPND_W-2]) begin
      err_d = 32'sh8000_0000;
    end else if (diff == 33'sh1_8000_0000) begin
      err_d = 32'sh8000_0001;
    end else begin
      err_d = diff[DATA_W-1:0];
    end
  end

  assign derr = {err_q[DATA_W-1], err_q} - {last_q[DATA_W-1], last_q};

  // Shared multiplier operands.
  always_comb begin
    case (ctrl.mul_a)
      MA_ERR:    opa = {err_q[DATA_W-1], err_q};
      MA_GAIN_P: opa = {gain_p_q[DATA_W-1], gain_p_q};
      MA_GAIN_I: opa = {gain_i_q[DATA_W-1], gain_i_q};
      MA_GAIN_D: opa = {gain_d_q[DATA_W-1], gain_d_q};
      default:   opa = '0;
    endcase
    case (ctrl.mul_b)
      MB_PERIOD: opb = {1'b0, period_q};
      MB_ERR:    opb = {err_q[DATA_W-1], err_q};
      MB_ACC:    opb = {acc_q[DATA_W-1], acc_q};
      MB_DERR:   opb = derr;
      default:   opb = '0;
    endcase
  end

  // Integral update: the increment is the product scaled down by 2^32.
  assign acc_sum  = {acc_q[DATA_W-1], acc_q} + prod_q[64:32];
  assign ilim_ext = {2'b00, ilim_q};
  assign ilim_neg = -ilim_ext;

  always_comb begin
    if (acc_sum > ilim_ext) begin
      acc_d = ilim_ext[DATA_W-1:0];
    end else if (acc_sum < ilim_neg) begin
      acc_d = ilim_neg[DATA_W-1:0];
    end else begin
      acc_d = acc_sum[DATA_W-1:0];
    end
  end

  // Term accumulation: each product is scaled down by 2^16.
  assign term     = {{2{prod_q[PROD_W-1]}}, prod_q[PROD_W-1:16]};
  assign sum_next = sum_q + term;
  assign olim_ext = {{(SUM_W-LIM_W){1'b0}}, olim_q};

  always_comb begin
    if (sum_q > olim_ext) begin
      drive_d = {1'b0, olim_q};
    end else if (sum_q < -olim_ext) begin
      drive_d = -$signed({1'b0, olim_q});
    end else begin
      drive_d = sum_q[DATA_W-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= func_i;
      meas_q <= measured_i;
    end
    if (fire && ctrl.err_en) begin
      err_q <= err_d;
    end
    if (fire && ctrl.mul_en) begin
      prod_q <= opa * opb;
    end
    if (fire) begin
      case (ctrl.sum_op)
        SUM_CLR: sum_q <= '0;
        SUM_ADD: sum_q <= sum_next;
        default: ;
      endcase
    end
    if (fire && ctrl.out_en) begin
      drive_q <= drive_d;
    end
  end

  // Controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      last_q <= '0;
    end else if (fire && ctrl.clr_en) begin
      acc_q  <= '0;
      last_q <= '0;
    end else begin
      if (fire && ctrl.acc_en) begin
        acc_q <= acc_d[DATA_W-1:0];
      end
      if (fire && ctrl.last_en) begin
        last_q <= err_q;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && ctrl.out_en) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("accepted transaction did not start the program");

  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ctrl.out_en) |-> !(out_valid_q && out_stall_i))
    else $error("result written over a pending output");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && ctrl.clr_en) |=> (acc_q == '0 && last_q == '0))
    else $error("clear did not zero the controller state");

  a_drive_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_o <= $signed({1'b0, olim_q}) &&
                     drive_o >= -$signed({1'b0, olim_q})))
    else $error("drive value outside the output limit");
`endif

endmodule
